// File: hdl/meos_pkg.sv
// ----------------------------------------------------------------------------
// meos_pkg
// shared constants and controller/datapath interface types for the
// midpoint ellipse octant stepper
// ----------------------------------------------------------------------------
package meos_pkg;

    // default radius width
    localparam int RADIUS_BITS_DEF = 10;

    // width of the decision index within an octant
    localparam int IDX_BITS = 10;

    // request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load_radii;   // start request: capture radii and squares
        logic prod_en;      // capture square times radius product
        logic init_en;      // set up threshold and adjust terms
        logic stage1_en;    // first half of a decision
        logic commit;       // second half of a decision, state update
        logic phase;        // 0 = x-major octant, 1 = y-major octant
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic                diag;
        logic                last;
        logic [IDX_BITS-1:0] step_index;
    } t_dp_sts;

endpackage

// File: hdl/meos_datapath.sv
// ----------------------------------------------------------------------------
// meos_datapath
// squares, setup product, threshold and adjust registers, decision sums then commit
// ----------------------------------------------------------------------------
module meos_datapath #(
    parameter int RADIUS_BITS = meos_pkg::RADIUS_BITS_DEF
) (
    input  logic                   i_clk,
    input  meos_pkg::t_dp_cmd      i_cmd,
    input  logic [RADIUS_BITS-1:0] i_radius_x,
    input  logic [RADIUS_BITS-1:0] i_radius_y,
    output meos_pkg::t_dp_sts      o_sts
);
    import meos_pkg::*;

    localparam int SQW = 2 * RADIUS_BITS;
    localparam int PRW = 3 * RADIUS_BITS;
    localparam int W   = 3 * RADIUS_BITS + 4;
    localparam int ZW  = W - SQW;
    localparam int PZW = W - PRW;

    logic [SQW-1:0]         r_a_sq;
    logic [SQW-1:0]         r_b_sq;
    logic [RADIUS_BITS-1:0] r_rad_a;
    logic [RADIUS_BITS-1:0] r_rad_b;
    logic [PRW-1:0]         r_prod;
    logic signed [W-1:0]    r_threshold;
    logic signed [W-1:0]    r_major;
    logic signed [W-1:0]    r_minor;
    logic [IDX_BITS-1:0]    r_step_count;
    logic signed [W-1:0]    r_t1;
    logic signed [W-1:0]    r_minor_dec;
    logic signed [W-1:0]    r_major_inc;

    logic [SQW-1:0]         sq_x;
    logic [SQW-1:0]         sq_y;
    logic [SQW-1:0]         mul_l;
    logic [RADIUS_BITS-1:0] mul_r;
    logic [PRW-1:0]         prod_w;
    logic [SQW-1:0]         inc_sq;
    logic [SQW-1:0]         dec_sq;
    logic signed [W-1:0]    inc_ext;
    logic signed [W-1:0]    inc2_ext;
    logic signed [W-1:0]    dec2_ext;
    logic signed [W-1:0]    quarter_ext;
    logic signed [W-1:0]    prod_ext;
    logic signed [W-1:0]    prod2_ext;
    logic                   diag;
    logic signed [W-1:0]    minor_new;
    logic                   last;

    // start squares straight from the request
    assign sq_x = SQW'(i_radius_x) * SQW'(i_radius_x);
    assign sq_y = SQW'(i_radius_y) * SQW'(i_radius_y);

    // x octant: a^2 * b, y octant: b^2 * a
    assign mul_l  = i_cmd.phase ? r_b_sq : r_a_sq;
    assign mul_r  = i_cmd.phase ? r_rad_a : r_rad_b;
    assign prod_w = PRW'(mul_l) * PRW'(mul_r);

    // major axis term grows by the other square, minor term shrinks by own
    assign inc_sq = i_cmd.phase ? r_a_sq : r_b_sq;
    assign dec_sq = i_cmd.phase ? r_b_sq : r_a_sq;

    assign inc_ext     = {{ZW{1'b0}}, inc_sq};
    assign inc2_ext    = {{(ZW-1){1'b0}}, inc_sq, 1'b0};
    assign dec2_ext    = {{(ZW-1){1'b0}}, dec_sq, 1'b0};
    assign quarter_ext = {{(ZW+2){1'b0}}, mul_l[SQW-1:2]};
    assign prod_ext    = {{PZW{1'b0}}, r_prod};
    assign prod2_ext   = {{(PZW-1){1'b0}}, r_prod, 1'b0};

    // second half of a decision
    assign diag      = ~r_t1[W-1];
    assign minor_new = diag ? r_minor_dec : r_minor;
    assign last      = i_cmd.phase ? (r_major_inc > minor_new)
                                   : (r_major_inc >= minor_new);

    assign o_sts.diag       = diag;
    assign o_sts.last       = last;
    assign o_sts.step_index = r_step_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_radii) begin
            r_rad_a <= i_radius_x;
            r_rad_b <= i_radius_y;
            r_a_sq  <= sq_x;
            r_b_sq  <= sq_y;
        end
        if (i_cmd.prod_en) begin
            r_prod <= prod_w;
        end
        if (i_cmd.init_en) begin
            r_threshold  <= quarter_ext - prod_ext;
            r_minor      <= prod2_ext;
            r_major      <= '0;
            r_step_count <= '0;
        end
        if (i_cmd.stage1_en) begin
            r_t1        <= r_threshold + r_major + inc_ext;
            r_minor_dec <= r_minor - dec2_ext;
            r_major_inc <= r_major + inc2_ext;
        end
        if (i_cmd.commit) begin
            r_threshold <= diag ? (r_t1 - r_minor_dec) : r_t1;
            r_minor     <= minor_new;
            r_major     <= r_major_inc;
            r_step_count <= last ? '0 : (r_step_count + 1'b1);
        end
    end

endmodule

// File: hdl/meos_ctrl.sv
// ----------------------------------------------------------------------------
// meos_ctrl
// request handshake, octant mode, sequencing and the result register
// ----------------------------------------------------------------------------
module meos_ctrl #(
    parameter int RADIUS_BITS = meos_pkg::RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [RADIUS_BITS-1:0]        i_radius_x,
    input  logic [RADIUS_BITS-1:0]        i_radius_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_phase,
    output logic                          o_diagonal,
    output logic [meos_pkg::IDX_BITS-1:0] o_step_index,
    output logic                          o_last,
    output logic                          o_error,
    output meos_pkg::t_dp_cmd             o_cmd,
    input  meos_pkg::t_dp_sts             i_sts
);
    import meos_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_XRUN,
        MODE_YSETUP,
        MODE_YRUN
    } t_mode;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_PROD,
        ST_INIT,
        ST_YINIT,
        ST_STEP1,
        ST_STEP2,
        ST_EMIT
    } t_state;

    t_state              r_state;
    t_mode               r_mode;
    logic                r_out_valid;
    logic                r_out_phase;
    logic                r_out_diag;
    logic [IDX_BITS-1:0] r_out_idx;
    logic                r_out_last;
    logic                r_out_err;

    logic accept;
    logic zero_radius;
    logic out_free;
    logic out_load;
    logic running;

    assign o_in_stall  = (r_state != ST_WAIT) || !i_rst_n;
    assign accept      = i_in_valid && !o_in_stall;
    assign zero_radius = (i_radius_x == '0) || (i_radius_y == '0);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = ((r_state == ST_STEP2) || (r_state == ST_EMIT)) && out_free;
    assign running     = (r_mode == MODE_XRUN) || (r_mode == MODE_YRUN);

    always_comb begin
        o_cmd            = '0;
        o_cmd.phase      = (r_mode == MODE_YRUN) || (r_mode == MODE_YSETUP);
        o_cmd.load_radii = accept && (i_op == OP_START) && !zero_radius;
        o_cmd.prod_en    = (r_state == ST_PROD)
                        || (accept && (i_op == OP_STEP) && (r_mode == MODE_YSETUP));
        o_cmd.init_en    = (r_state == ST_INIT) || (r_state == ST_YINIT);
        o_cmd.stage1_en  = (r_state == ST_STEP1)
                        || (accept && (i_op == OP_STEP) && running);
        o_cmd.commit     = (r_state == ST_STEP2) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_mode      <= MODE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_WAIT: begin
                    if (accept) begin
                        if (i_op == OP_START) begin
                            if (zero_radius) begin
                                r_mode  <= MODE_IDLE;
                                r_state <= ST_EMIT;
                            end else begin
                                r_mode  <= MODE_XRUN;
                                r_state <= ST_PROD;
                            end
                        end else begin
                            unique case (r_mode)
                                MODE_IDLE:   r_state <= ST_EMIT;
                                MODE_YSETUP: r_state <= ST_YINIT;
                                default:     r_state <= ST_STEP2;
                            endcase
                        end
                    end
                end
                ST_PROD:  r_state <= ST_INIT;
                ST_INIT:  r_state <= ST_WAIT;
                ST_YINIT: begin
                    r_mode  <= MODE_YRUN;
                    r_state <= ST_STEP1;
                end
                ST_STEP1: r_state <= ST_STEP2;
                ST_STEP2: begin
                    if (out_free) begin
                        r_out_phase <= o_cmd.phase;
                        r_out_diag  <= i_sts.diag;
                        r_out_idx   <= i_sts.step_index;
                        r_out_last  <= i_sts.last;
                        r_out_err   <= 1'b0;
                        if (i_sts.last) begin
                            r_mode <= (r_mode == MODE_XRUN) ? MODE_YSETUP : MODE_IDLE;
                        end
                        r_state <= ST_WAIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_phase <= 1'b0;
                        r_out_diag  <= 1'b0;
                        r_out_idx   <= '0;
                        r_out_last  <= 1'b0;
                        r_out_err   <= 1'b1;
                        r_state     <= ST_WAIT;
                    end
                end
                default: r_state <= ST_WAIT;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_phase      = r_out_phase;
    assign o_diagonal   = r_out_diag;
    assign o_step_index = r_out_idx;
    assign o_last       = r_out_last;
    assign o_error      = r_out_err;

    // a step in a running octant goes straight to the commit cycle
    a_step_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_op == OP_STEP) && running |=> r_state == ST_STEP2)
        else $error("running step did not reach commit");

    // zero radius start drops the ellipse and reports an error
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_op == OP_START) && zero_radius
        |=> (r_state == ST_EMIT) && (r_mode == MODE_IDLE))
        else $error("zero radius start not flagged");

    // last decision of the y-major octant ends the ellipse
    a_y_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP2) && out_free && i_sts.last && (r_mode == MODE_YRUN)
        |=> r_mode == MODE_IDLE)
        else $error("ellipse did not end after y-major octant");

    // an error result carries no decision
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err
        |-> !r_out_phase && !r_out_diag && (r_out_idx == '0) && !r_out_last)
        else $error("error result with decision fields set");

endmodule

// File: hdl/midpoint_ellipse_octant_stepper.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_octant_stepper
// integer midpoint ellipse decisions over the x-major then y-major octant
// ----------------------------------------------------------------------------
// sequencing: a step request in a running octant registers the decision
//   sums at the accepting edge, then compares, updates and loads the output
//   register once it is free; the first step of the y-major octant first forms
//   the product of b^2 and a, then setup, then the sums; an error result goes
//   straight to the output register; no request is taken until the last is done
// start: squares, one shared square-times-radius multiplier, setup; no result
// reset: synchronous, active low; clears mode, sequencer and result valid,
//   arithmetic registers are not cleared since idle mode never reads them
// ----------------------------------------------------------------------------
module midpoint_ellipse_octant_stepper #(
    parameter int RADIUS_BITS = meos_pkg::RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [RADIUS_BITS-1:0]        i_radius_x,
    input  logic [RADIUS_BITS-1:0]        i_radius_y,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_phase,
    output logic                          o_diagonal,
    output logic [meos_pkg::IDX_BITS-1:0] o_step_index,
    output logic                          o_last,
    output logic                          o_error
);
    import meos_pkg::*;

    // command and status between sequencer and arithmetic
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: handshake, octant mode, result register
    meos_ctrl #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_radius_x   (i_radius_x),
        .i_radius_y   (i_radius_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_phase      (o_phase),
        .o_diagonal   (o_diagonal),
        .o_step_index (o_step_index),
        .o_last       (o_last),
        .o_error      (o_error),
        .o_cmd        (dp_cmd),
        .i_sts        (dp_sts)
    );

    // arithmetic: squares, setup product, decision variable
    meos_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .i_radius_x (i_radius_x),
        .i_radius_y (i_radius_y),
        .o_sts      (dp_sts)
    );

endmodule
